@@ rtl/core/slkv_pkg.sv @@
package slkv_pkg;

    localparam int LEAF_ENTRIES = 32;
    localparam int KEY_BITS     = 64;
    localparam int VALUE_BITS   = 64;
    localparam int IDX_W        = $clog2(LEAF_ENTRIES);
    localparam int CNT_W        = $clog2(LEAF_ENTRIES + 1);
    localparam int MAX_OUT      = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_SCAN   = 2'd2,
        REQ_SPLIT  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_INSERTED   = 4'd0,
        ST_UPDATED    = 4'd1,
        ST_FULL       = 4'd2,
        ST_FOUND      = 4'd3,
        ST_NOT_FOUND  = 4'd4,
        ST_SCAN_ENTRY = 4'd5,
        ST_SCAN_NONE  = 4'd6,
        ST_SPLIT_ENTRY = 4'd7,
        ST_SPLIT_REFUSED = 4'd8
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_PROBE_WAIT,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [63:0] value;
        logic [5:0]  scan_limit;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] entry_key;
        logic [63:0] entry_value;
        logic [63:0] separator_key;
        logic [5:0]  entries_now;
        logic        last;
    } out_item_t;

    // memory port request from sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_BITS-1:0]   wr_key;
        logic [VALUE_BITS-1:0] wr_value;
    } mem_req_t;

endpackage

@@ rtl/core/sorted_leaf_kv_node.sv @@
// Sorted leaf key/value node: binary search then one memory access per cycle.
// Each probe is a read then a wait state (up to 6 probes); then final read, decide, done;
// insert adds a read and a write state per shifted entry (up to 31), then a place state.
// Busy stays high while an item is in progress; start is taken only when busy is low.
// Scan/split: a read then an emit state per item; split first reads the separator slot.
// Reset clears entry count and sequencer, not stored entries; the receiver cannot stall.
module sorted_leaf_kv_node
    import slkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  req_in,
    output logic      busy,
    output logic      result_valid,
    output out_item_t result
);

    mem_req_t              mem;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;

    // sequencer drives the single shared memory port
    slkv_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_in       (req_in),
        .busy         (busy),
        .mem          (mem),
        .rd_key       (rd_key),
        .rd_value     (rd_value),
        .result_valid (result_valid),
        .result       (result)
    );

    slkv_store u_store (
        .clk      (clk),
        .req      (mem),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.entries_now <= 6'(LEAF_ENTRIES))
        else $error("entry count over capacity");

    a_no_result_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result right after accept");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= 4'd8)
        else $error("bad status");

endmodule

@@ rtl/core/slkv_store.sv @@
module slkv_store
    import slkv_pkg::*;
(
    input  logic                  clk,
    input  mem_req_t              req,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_value
);

    logic [KEY_BITS-1:0]   keys_mem   [LEAF_ENTRIES];
    logic [VALUE_BITS-1:0] values_mem [LEAF_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            keys_mem[req.wr_addr]   <= req.wr_key;
            values_mem[req.wr_addr] <= req.wr_value;
        end
        if (req.rd_en)
        begin
            rd_key   <= keys_mem[req.rd_addr];
            rd_value <= values_mem[req.rd_addr];
        end
    end

endmodule

@@ rtl/core/slkv_seq.sv @@
module slkv_seq
    import slkv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  in_item_t              req_in,
    output logic                  busy,
    output mem_req_t              mem,
    input  logic [KEY_BITS-1:0]   rd_key,
    input  logic [VALUE_BITS-1:0] rd_value,
    output logic                  result_valid,
    output out_item_t             result
);

    fsm_t state_reg, state_next;

    logic [1:0]            req_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CNT_W-1:0]      limit_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      end_reg, end_next;
    logic [KEY_BITS-1:0]   sep_reg, sep_next;
    logic [CNT_W-1:0]      mid;
    logic                  key_lt;
    logic                  key_eq;
    logic                  hit;
    logic [CNT_W-1:0]      avail;
    logic [CNT_W-1:0]      n_out;
    logic [CNT_W-1:0]      keep;
    out_item_t             res_reg, res_next;
    logic                  rv_reg, rv_next;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key_lt = rd_key[KEY_BITS-1:0] < key_reg;
    assign key_eq = rd_key == key_reg;
    assign hit    = (lo_reg < count_reg) && key_eq;
    assign avail  = count_reg - lo_reg;
    assign n_out  = (avail > limit_reg) ? limit_reg : avail;
    assign keep   = count_reg >> 1;
    assign busy   = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg   <= req_in.req_type;
            key_reg   <= req_in.key[KEY_BITS-1:0];
            value_reg <= req_in.value[VALUE_BITS-1:0];
            limit_reg <= (req_in.scan_limit > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT)
                                                              : req_in.scan_limit;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
        end_reg <= end_next;
        sep_reg <= sep_next;
        res_reg <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (start) state_next = S_PROBE;
            S_PROBE:      state_next = (lo_reg < hi_reg) ? S_PROBE_WAIT : S_DECIDE;
            S_PROBE_WAIT: state_next = S_PROBE;
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (req_reg)
                    REQ_INSERT:
                        if (count_reg < CNT_W'(LEAF_ENTRIES) && !hit && count_reg > lo_reg)
                            state_next = S_SHIFT_RD;
                    REQ_SCAN:
                        if (n_out != '0) state_next = S_EMIT_RD;
                    REQ_SPLIT:
                        if (count_reg >= CNT_W'(2)) state_next = S_EMIT_RD;
                    default: state_next = S_DONE;
                endcase
            end
            S_SHIFT_RD:   state_next = S_SHIFT_WR;
            S_SHIFT_WR:   state_next = (ptr_reg - CNT_W'(1) > lo_reg) ? S_SHIFT_RD : S_PLACE;
            S_PLACE:      state_next = S_DONE;
            S_EMIT_RD:    state_next = S_EMIT;
            S_EMIT:       state_next = (ptr_reg + CNT_W'(1) == end_reg) ? S_IDLE : S_EMIT_RD;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        sep_next   = sep_reg;
        count_next = count_reg;
        res_next   = res_reg;
        rv_next    = 1'b0;
        mem        = '0;
        case (state_reg)
            S_IDLE:
            begin
                lo_next = '0;
                hi_next = count_reg;
            end
            S_PROBE:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = (lo_reg < hi_reg) ? mid[IDX_W-1:0] : lo_reg[IDX_W-1:0];
            end
            S_PROBE_WAIT:
            begin
                if (key_lt) lo_next = mid + CNT_W'(1);
                else        hi_next = mid;
            end
            S_DECIDE:
            begin
                res_next.entry_key     = 64'(key_reg);
                res_next.entry_value   = '0;
                res_next.separator_key = '0;
                res_next.entries_now   = 6'(count_reg);
                res_next.last          = 1'b1;
                ptr_next = count_reg;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        res_next.entry_value = 64'(value_reg);
                        if (count_reg >= CNT_W'(LEAF_ENTRIES))
                            res_next.status = ST_FULL;
                        else if (hit)
                        begin
                            res_next.status = ST_UPDATED;
                            mem.wr_en    = 1'b1;
                            mem.wr_addr  = lo_reg[IDX_W-1:0];
                            mem.wr_key   = key_reg;
                            mem.wr_value = value_reg;
                        end
                        else
                        begin
                            res_next.status = ST_INSERTED;
                            count_next = count_reg + CNT_W'(1);
                            res_next.entries_now = 6'(count_reg + CNT_W'(1));
                            if (count_reg == lo_reg)
                            begin
                                mem.wr_en    = 1'b1;
                                mem.wr_addr  = lo_reg[IDX_W-1:0];
                                mem.wr_key   = key_reg;
                                mem.wr_value = value_reg;
                            end
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (hit)
                        begin
                            res_next.status      = ST_FOUND;
                            res_next.entry_value = 64'(rd_value);
                        end
                        else
                            res_next.status = ST_NOT_FOUND;
                    end
                    REQ_SCAN:
                    begin
                        res_next.status = ST_SCAN_NONE;
                        ptr_next = lo_reg;
                        end_next = lo_reg + n_out;
                    end
                    default:
                    begin
                        res_next.status = ST_SPLIT_REFUSED;
                        if (count_reg >= CNT_W'(2))
                        begin
                            ptr_next   = keep - CNT_W'(1);
                            end_next   = count_reg;
                            count_next = keep;
                        end
                    end
                endcase
                // single-result requests go out from S_DONE
            end
            S_SHIFT_RD:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = IDX_W'(ptr_reg - CNT_W'(1));
            end
            S_SHIFT_WR:
            begin
                mem.wr_en    = 1'b1;
                mem.wr_addr  = ptr_reg[IDX_W-1:0];
                mem.wr_key   = rd_key;
                mem.wr_value = rd_value;
                ptr_next     = ptr_reg - CNT_W'(1);
            end
            S_PLACE:
            begin
                // slot lo has been copied up; drop the new entry in
                mem.wr_en    = 1'b1;
                mem.wr_addr  = lo_reg[IDX_W-1:0];
                mem.wr_key   = key_reg;
                mem.wr_value = value_reg;
            end
            S_EMIT_RD:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = ptr_reg[IDX_W-1:0];
            end
            S_EMIT:
            begin
                if (req_reg == REQ_SPLIT && ptr_reg + CNT_W'(1) == count_reg)
                begin
                    // first pass reads the separator slot
                    sep_next = rd_key;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    rv_next = 1'b1;
                    res_next.status = (req_reg == REQ_SPLIT) ? ST_SPLIT_ENTRY
                                                             : ST_SCAN_ENTRY;
                    res_next.entry_key     = 64'(rd_key);
                    res_next.entry_value   = 64'(rd_value);
                    res_next.separator_key = (req_reg == REQ_SPLIT) ? 64'(sep_reg) : '0;
                    res_next.entries_now   = 6'(count_reg);
                    res_next.last          = (ptr_reg + CNT_W'(1) == end_reg);
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                rv_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
